@@ rtl/core/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, constants and tables of the stochastic approximation tracker.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int SAT_SAMPLE_WIDTH = 24;
  localparam int SAT_COUNT_WIDTH  = 32;

  // register indexes of the configuration port
  localparam logic [2:0] CFG_START  = 3'd0;
  localparam logic [2:0] CFG_GAIN   = 3'd1;
  localparam logic [2:0] CFG_EXP    = 3'd2;
  localparam logic [2:0] CFG_LEVEL  = 3'd3;
  localparam logic [2:0] CFG_MODE   = 3'd4;
  localparam logic [2:0] CFG_SQUARE = 3'd5;

  localparam logic signed [23:0] START_RST  = 24'sd655360;
  localparam logic [23:0]        GAIN_RST   = 24'd65536;
  localparam logic [15:0]        EXP_RST    = 16'd16384;
  localparam logic [15:0]        LEVEL_RST  = 16'd62259;

  localparam logic MODE_MEAN     = 1'b0;
  localparam logic MODE_QUANTILE = 1'b1;

  typedef struct packed {
    logic signed [23:0] start;
    logic [23:0]        gain;
    logic [15:0]        expo;
    logic [15:0]        level;
    logic               mode;
    logic               square;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG,
    ST_EXPM,
    ST_POW,
    ST_GAIN,
    ST_SHIFT,
    ST_SQUARE,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef logic [30:0] root_tab_t [16];

  function automatic longint unsigned sat_isqrt(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned b;
    v   = v_in;
    res = 0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
    end
    return res;
  endfunction

  // r_k = 2^(-2^-(k+1)) in Q.30, each from a truncated square root of the last
  function automatic root_tab_t sat_roots();
    root_tab_t       tab;
    longint unsigned r;
    r = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      r      = sat_isqrt(r << 30);
      tab[k] = r[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOTS = sat_roots();

endpackage

@@ rtl/core/sat_front.sv @@
// ----------------------------------------------------------------------------
// sat_front
// Input side: takes sample words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sat_front #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           q_valid,
  input  logic                           q_pop,
  output logic signed [SAMPLE_WIDTH-1:0] q_sample,
  output logic                           q_restart
);

  logic signed [SAMPLE_WIDTH-1:0] mem_sample [2];
  logic                           mem_restart [2];
  logic                           wp_r, rp_r;
  logic [1:0]                     cnt_r, cnt_nxt;
  logic                           push;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_sample  = mem_sample[rp_r];
  assign q_restart = mem_restart[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_sample[wp_r]  <= in_sample;
      mem_restart[wp_r] <= in_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/sat_back.sv @@
// ----------------------------------------------------------------------------
// sat_back
// Step-size sequencer and estimate update around one shared multiplier.
// ----------------------------------------------------------------------------
module sat_back #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sat_pkg::cfg_t                  cfg,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  logic                           q_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_estimate,
  output logic [23:0]                    out_step_size,
  output logic                           out_saturated
);
  import sat_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int NW   = COUNT_WIDTH + 1;
  localparam int XW   = (NW > 31) ? NW : 31;
  localparam int PBW  = $clog2(XW);
  localparam int FW   = (SW + 1 > 18) ? SW + 1 : 18;
  localparam int NC   = (FW + 23) / 24;
  localparam int NCB  = (NC > 1) ? $clog2(NC) : 1;
  localparam int MAGW = NC * 24;
  localparam int PW   = MAGW + 24;
  localparam int DW   = PW + 1 - 16;
  localparam int CLW  = ((SW > 24) ? SW : 24) + 1;

  localparam logic signed [SW-1:0] EMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] EMIN = {1'b1, {(SW-1){1'b0}}};

  state_t state_r, state_nxt;

  logic [XW-1:0]          x_r, x_nxt;
  logic [PBW-1:0]         p_r, p_nxt;
  logic [30:0]            m_r, m_nxt;
  logic [15:0]            frac_r, frac_nxt;
  logic [3:0]             it_r, it_nxt;
  logic [PBW+1:0]         ip_r, ip_nxt;
  logic [15:0]            f_r, f_nxt;
  logic [30:0]            acc_r, acc_nxt;
  logic [54:0]            gp_r, gp_nxt;
  logic [23:0]            step_r, step_nxt;
  logic [MAGW-1:0]        mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [PW-1:0]          pacc_r, pacc_nxt;
  logic [NCB-1:0]         ci_r, ci_nxt;
  logic signed [SW-1:0]   est_r, est_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]   out_est_r, out_est_nxt;
  logic [23:0]            out_step_r, out_step_nxt;
  logic                   out_sat_r, out_sat_nxt;

  logic [30:0]            mul_a, mul_b;
  logic [61:0]            prod;

  logic signed [CLW-1:0]  st_x, st_rst_x;
  logic signed [SW-1:0]   st_clip, st_rst;
  logic signed [SW-1:0]   est_cur;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic signed [FW-1:0]   fval;
  logic [FW-1:0]          fmag;
  logic [17:0]            qpos;
  logic [PBW+15:0]        lg;
  logic [8:0]             sh;
  logic [54:0]            gsh;
  logic signed [PW:0]     sp;
  logic signed [DW-1:0]   delta;
  logic signed [DW:0]     nv;
  logic signed [SW-1:0]   nv_clip;
  logic                   nv_sat;
  logic                   out_free;

  // restart value, clipped to the estimate range
  always_comb begin
    st_x     = CLW'(cfg.start);
    st_rst_x = CLW'(START_RST);
    if (st_x > CLW'(EMAX))      st_clip = EMAX;
    else if (st_x < CLW'(EMIN)) st_clip = EMIN;
    else                        st_clip = SW'(st_x);
    if (st_rst_x > CLW'(EMAX))      st_rst = EMAX;
    else if (st_rst_x < CLW'(EMIN)) st_rst = EMIN;
    else                            st_rst = SW'(st_rst_x);
  end

  assign est_cur = q_restart ? st_clip : est_r;
  assign cnt_cur = q_restart ? '0 : cnt_r;

  always_comb begin
    qpos = 18'd65536 - 18'(cfg.level);
    if (cfg.mode == MODE_MEAN) begin
      fval = FW'(est_cur) - FW'(q_sample);
    end else if (q_sample <= est_cur) begin
      fval = signed'(FW'(qpos));
    end else begin
      fval = -signed'(FW'(cfg.level));
    end
    fmag = fval[FW-1] ? FW'(-fval) : FW'(fval);
  end

  assign lg = {p_r, frac_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOG: begin
        mul_a = m_r;
        mul_b = m_r;
      end
      ST_EXPM: begin
        mul_a = 31'(lg);
        mul_b = 31'(cfg.expo);
      end
      ST_POW: begin
        mul_a = acc_r;
        mul_b = ROOTS[it_r];
      end
      ST_GAIN: begin
        mul_a = 31'(cfg.gain);
        mul_b = acc_r;
      end
      ST_SQUARE: begin
        mul_a = 31'(step_r);
        mul_b = 31'(step_r);
      end
      ST_MUL: begin
        mul_a = 31'(mag_r[MAGW-1 -: 24]);
        mul_b = 31'(step_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {31'b0, mul_a} * {31'b0, mul_b};

  assign sh  = 9'd30 + 9'(ip_r);
  assign gsh = gp_r >> sh;

  // floor(F * step / 2^16) and the clipped new estimate
  always_comb begin
    sp    = neg_r ? -signed'({1'b0, pacc_r}) : signed'({1'b0, pacc_r});
    delta = DW'(sp >>> 16);
    nv    = (DW+1)'(est_r) - (DW+1)'(delta);
    nv_sat = 1'b1;
    if (nv > (DW+1)'(EMAX))      nv_clip = EMAX;
    else if (nv < (DW+1)'(EMIN)) nv_clip = EMIN;
    else begin
      nv_clip = SW'(nv);
      nv_sat  = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_NORM;
      ST_NORM:   if (x_r[XW-1]) state_nxt = ST_LOG;
      ST_LOG:    if (it_r == 4'd15) state_nxt = ST_EXPM;
      ST_EXPM:   state_nxt = ST_POW;
      ST_POW:    if (it_r == 4'd15) state_nxt = ST_GAIN;
      ST_GAIN:   state_nxt = ST_SHIFT;
      ST_SHIFT:  state_nxt = cfg.square ? ST_SQUARE : ST_MUL;
      ST_SQUARE: state_nxt = ST_MUL;
      ST_MUL:    if (ci_r == NCB'(NC - 1)) state_nxt = ST_UPD;
      ST_UPD:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign q_pop = (state_r == ST_IDLE) && q_valid;

  // datapath
  always_comb begin
    x_nxt         = x_r;
    p_nxt         = p_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    it_nxt        = it_r;
    ip_nxt        = ip_r;
    f_nxt         = f_r;
    acc_nxt       = acc_r;
    gp_nxt        = gp_r;
    step_nxt      = step_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    pacc_nxt      = pacc_r;
    ci_nxt        = ci_r;
    est_nxt       = est_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_est_nxt   = out_est_r;
    out_step_nxt  = out_step_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          est_nxt  = est_cur;
          cnt_nxt  = cnt_cur;
          x_nxt    = XW'(cnt_cur) + XW'(1);
          p_nxt    = PBW'(XW - 1);
          mag_nxt  = MAGW'(fmag);
          neg_nxt  = fval[FW-1];
          pacc_nxt = '0;
        end
      end
      ST_NORM: begin
        if (x_r[XW-1]) begin
          m_nxt    = x_r[XW-1 -: 31];
          it_nxt   = '0;
          frac_nxt = '0;
        end else begin
          x_nxt = x_r << 1;
          p_nxt = p_r - PBW'(1);
        end
      end
      ST_LOG: begin
        frac_nxt = {frac_r[14:0], prod[61]};
        m_nxt    = prod[61] ? prod[61:31] : prod[60:30];
        it_nxt   = it_r + 4'd1;
      end
      ST_EXPM: begin
        ip_nxt  = prod[PBW+31:30];
        f_nxt   = prod[29:14];
        acc_nxt = 31'h4000_0000;
        it_nxt  = '0;
      end
      ST_POW: begin
        if (f_r[15]) acc_nxt = prod[60:30];
        f_nxt  = f_r << 1;
        it_nxt = it_r + 4'd1;
      end
      ST_GAIN: begin
        gp_nxt = prod[54:0];
      end
      ST_SHIFT: begin
        step_nxt = (sh >= 9'd64) ? 24'd0 : gsh[23:0];
        ci_nxt   = '0;
      end
      ST_SQUARE: begin
        step_nxt = (prod[47:40] != 8'd0) ? 24'hFF_FFFF : prod[39:16];
      end
      ST_MUL: begin
        pacc_nxt = (pacc_r << 24) + PW'(prod[47:0]);
        mag_nxt  = mag_r << 24;
        ci_nxt   = ci_r + NCB'(1);
      end
      ST_UPD: begin
        if (out_free) begin
          est_nxt       = nv_clip;
          cnt_nxt       = (cnt_r == '1) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
          out_valid_nxt = 1'b1;
          out_est_nxt   = nv_clip;
          out_step_nxt  = step_r;
          out_sat_nxt   = nv_sat;
        end
      end
      default: begin
        x_nxt = x_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    m_r        <= m_nxt;
    frac_r     <= frac_nxt;
    it_r       <= it_nxt;
    ip_r       <= ip_nxt;
    f_r        <= f_nxt;
    acc_r      <= acc_nxt;
    gp_r       <= gp_nxt;
    step_r     <= step_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    pacc_r     <= pacc_nxt;
    ci_r       <= ci_nxt;
    out_est_r  <= out_est_nxt;
    out_step_r <= out_step_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      est_r       <= st_rst;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      est_r       <= est_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_estimate  = out_est_r;
  assign out_step_size = out_step_r;
  assign out_saturated = out_sat_r;

endmodule

@@ rtl/core/stochastic_approximation_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// stochastic_approximation_tracker_unit
// Robbins-Monro tracker of a mean or a quantile over a Q8.16 sample stream.
// ----------------------------------------------------------------------------
// Input words (in_sample, in_restart) enter a two-entry queue over valid and
// ready. The back end takes one word at a time, forms the step size
// gain / (count+1)^exponent with one shared 31x31 multiplier and updates the
// estimate. Per word it steps through: a pop, a leading-one scan of
// count+1 over COUNT_WIDTH+1 bits (at least 31 wide), a log loop over
// 16 fraction bits, one exponent multiply, a power loop over 16 fraction
// bits, gain multiply, shift, the squared step when set, the product over
// the sample error in 24-bit chunks and the update; the scan takes longer
// while the count is small. The result word sits in an output register;
// while the receiver stalls the back end finishes the next word up to its
// update and waits, and the queue keeps taking input until full. Reset
// clears the queue and output, loads the estimate with the start value
// reset, zeroes the count and restores the register reset values. The user
// must write registers over cfg_we, cfg_idx and cfg_wdata only while no
// word is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module stochastic_approximation_tracker_unit #(
  parameter int SAMPLE_WIDTH = sat_pkg::SAT_SAMPLE_WIDTH,
  parameter int COUNT_WIDTH  = sat_pkg::SAT_COUNT_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_idx,
  input  logic [23:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_estimate,
  output logic [23:0]                    out_step_size,
  output logic                           out_saturated
);
  import sat_pkg::*;

  cfg_t cfg_r;

  logic                           q_valid, q_pop, q_restart;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start  <= START_RST;
      cfg_r.gain   <= GAIN_RST;
      cfg_r.expo   <= EXP_RST;
      cfg_r.level  <= LEVEL_RST;
      cfg_r.mode   <= MODE_MEAN;
      cfg_r.square <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_START:  cfg_r.start  <= signed'(cfg_wdata);
        CFG_GAIN:   cfg_r.gain   <= cfg_wdata;
        CFG_EXP:    cfg_r.expo   <= cfg_wdata[15:0];
        CFG_LEVEL:  cfg_r.level  <= cfg_wdata[15:0];
        CFG_MODE:   cfg_r.mode   <= cfg_wdata[0];
        CFG_SQUARE: cfg_r.square <= cfg_wdata[0];
        default:    cfg_r.square <= cfg_r.square;
      endcase
    end
  end

  sat_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .in_restart(in_restart),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sample  (q_sample),
    .q_restart (q_restart)
  );

  sat_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_sample     (q_sample),
    .q_restart    (q_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .out_step_size(out_step_size),
    .out_saturated(out_saturated)
  );

endmodule

@@ verif/stochastic_approximation_tracker_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stochastic_approximation_tracker_unit_tb
// Drives Q8.16 sample words through the tracker under several register
// settings and handshake pressures; it checks typed directed words against
// planned values, the rest against a bit-exact step size and estimate model.
// ----------------------------------------------------------------------------
module stochastic_approximation_tracker_unit_tb;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 192;

  typedef struct packed {
    logic [23:0] est;
    logic [23:0] step;
    logic        sat;
  } result_t;

  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [23:0] val;
    logic [23:0] sample;
    bit          restart;
    bit          typed;
    result_t     want;
  } plan_row_t;

  // directed words: reset state, extremes, clipping, squared overflow,
  // quantile levels, exponents 0 and 0xFFFF, start value extremes, zero gain
  localparam plan_row_t PLAN [28] = '{
    '{0, CFG_START, 24'h0, 24'h0A0000, 1'b0, 1'b1, '{24'h0A0000, 24'h010000, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h7FFFFF, 1'b1, 1'b1, '{24'h7FFFFF, 24'h010000, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h800000, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h800000, 1'b1, 1'b1, '{24'h800000, 24'h010000, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000000, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_GAIN,  24'hFFFFFF, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h800000, 1'b1, 1'b1, '{24'h800000, 24'hFFFFFF, 1'b1}},
    '{0, CFG_START, 24'h0, 24'h7FFFFF, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_SQUARE, 24'h1, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000000, 1'b1, 1'b1, '{24'h800000, 24'hFFFFFF, 1'b1}},
    '{1, CFG_GAIN,  24'h010000, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_MODE,  24'h1, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_LEVEL, 24'h0, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000000, 1'b1, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h7FFFFF, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_LEVEL, 24'hFFFF, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h800000, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h7FFFFF, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_EXP,   24'h0, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000000, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_EXP,   24'hFFFF, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000064, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_START, 24'h800000, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h000005, 1'b1, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_START, 24'h7FFFFF, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'hFFFFFF, 1'b1, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{1, CFG_GAIN,  24'h0, 24'h0, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}},
    '{0, CFG_START, 24'h0, 24'h123456, 1'b0, 1'b0, '{24'h0, 24'h0, 1'b0}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_idx = CFG_START;
  logic [23:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [23:0]  in_sample = '0;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [23:0]  out_estimate;
  logic [23:0]         out_step_size;
  logic                out_saturated;

  // model registers and state
  logic signed [23:0]  m_start = START_RST;
  logic [23:0]         m_gain = GAIN_RST;
  logic [15:0]         m_exp = EXP_RST;
  logic [15:0]         m_level = LEVEL_RST;
  logic                m_mode = MODE_MEAN;
  logic                m_square = 1'b0;
  longint              est_now = 655360;
  longint unsigned     count_now = 0;
  longint unsigned     half_roots [16];

  result_t             pending_results [$];
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  int                  mismatches = 0;
  int                  words_sent = 0;
  int                  words_checked = 0;
  int                  sat_seen = 0;
  int                  cycles = 0;

  stochastic_approximation_tracker_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_estimate (out_estimate),
    .out_step_size(out_step_size),
    .out_saturated(out_saturated)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned probe;
    rest  = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [23:0] val);
    case (idx)
      CFG_START:  m_start = val;
      CFG_GAIN:   m_gain = val;
      CFG_EXP:    m_exp = val[15:0];
      CFG_LEVEL:  m_level = val[15:0];
      CFG_MODE:   m_mode = val[0];
      CFG_SQUARE: m_square = val[0];
      default: ;
    endcase
  endfunction

  // one tracker step: step size from the count, then the clipped update
  function automatic result_t track_word(input logic signed [23:0] sample,
                                         input logic restart);
    result_t         res;
    logic [63:0]     n;
    logic [63:0]     fr;
    longint unsigned m, frac, lg, e16, ip, acc, sh, stepv, mag, hi, lo, lop, q;
    longint          fval, delta, nv;
    bit              neg;
    int              p;
    if (restart) begin
      est_now   = m_start;
      count_now = 0;
    end
    n = count_now + 1;
    p = 63;
    while (p > 0 && !n[p]) p--;
    m = (p >= 30) ? (n >> (p - 30)) : (n << (30 - p));
    frac = 0;
    for (int k = 0; k < 16; k++) begin
      m    = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m    = m >> 1;
      end
    end
    lg  = (longint'(p) << 16) | frac;
    e16 = (lg * m_exp) >> 14;
    ip  = e16 >> 16;
    fr  = e16 & 64'hFFFF;
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (fr[16-k]) acc = (acc * half_roots[k-1]) >> 30;
    end
    sh    = 30 + ip;
    stepv = (sh >= 64) ? 0 : ((longint'(m_gain) * acc) >> sh);
    if (m_square) begin
      stepv = (stepv * stepv) >> 16;
      if (stepv > 64'hFFFFFF) stepv = 64'hFFFFFF;
    end
    if (m_mode == MODE_MEAN) fval = est_now - longint'(sample);
    else if (longint'(sample) <= est_now) fval = 65536 - longint'(m_level);
    else fval = -longint'(m_level);
    neg   = fval < 0;
    mag   = neg ? -fval : fval;
    hi    = mag >> 24;
    lo    = mag & 64'hFFFFFF;
    lop   = lo * stepv;
    q     = ((hi * stepv) << 8) + (lop >> 16);
    if (neg) delta = -$signed(q + ((lop & 64'hFFFF) != 0));
    else delta = $signed(q);
    nv = est_now - delta;
    res.sat = 1'b0;
    if (nv > 64'sd8388607) begin
      nv      = 8388607;
      res.sat = 1'b1;
    end
    if (nv < -64'sd8388608) begin
      nv      = -8388608;
      res.sat = 1'b1;
    end
    est_now = nv;
    if (count_now < 64'hFFFFFFFF) count_now++;
    res.est  = nv[23:0];
    res.step = stepv[23:0];
    return res;
  endfunction

  task automatic send_word(input logic [23:0] sample, input logic restart,
                           input bit typed, input result_t want);
    result_t got;
    in_sample  <= sample;
    in_restart <= restart;
    in_valid   <= 1'b1;
    do @(posedge clk); while (!in_ready);
    got = track_word(sample, restart);
    pending_results.insert(pending_results.size(), typed ? want : got);
    words_sent++;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [23:0] pick(input logic [23:0] lo_v, input logic [23:0] hi_v,
                                       input logic [23:0] rnd, input int phase);
    if (phase == 0) return lo_v;
    if (phase == 1) return hi_v;
    case ($urandom_range(4))
      0: return lo_v;
      1: return hi_v;
      default: return rnd;
    endcase
  endfunction

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: estimate %0d", out_estimate);
        mismatches++;
      end else begin
        result_t want;
        want = pending_results.pop_front();
        words_checked++;
        if (out_saturated) sat_seen++;
        if (out_estimate !== want.est) begin
          $error("estimate: expected %0d, got %0d", $signed(want.est), out_estimate);
          mismatches++;
        end
        if (out_step_size !== want.step) begin
          $error("step_size: expected %0d, got %0d", want.step, out_step_size);
          mismatches++;
        end
        if (out_saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, out_saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [23:0] smp;
    half_roots[0] = 64'd1 << 29;
    for (int k = 0; k < 16; k++)
      half_roots[k] = floor_sqrt((k == 0 ? (64'd1 << 29) : half_roots[k-1]) << 30);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].is_cfg) begin
        drain();
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        send_word(PLAN[i].sample, PLAN[i].restart, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      // idle modes: none, sender, receiver, both lightly
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      write_reg(CFG_START, pick(24'h800000, 24'h7FFFFF, 24'($urandom), ph));
      write_reg(CFG_GAIN, pick(24'h0, 24'hFFFFFF,
                               24'(($urandom_range(3) == 0) ? $urandom
                                                            : $urandom_range(1 << 18)), ph));
      write_reg(CFG_EXP, pick(24'h0, 24'hFFFF, 24'({8'($urandom_range(255)), 16'(
                              $urandom_range(32768))}), ph));
      write_reg(CFG_LEVEL, pick(24'h0, 24'hFFFF, 24'($urandom), ph));
      write_reg(CFG_MODE, (ph < 2) ? 24'(ph) : 24'($urandom_range(1)));
      write_reg(CFG_SQUARE, (ph < 2) ? 24'(ph) : 24'($urandom_range(1)));
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // mostly samples near the estimate so it settles, some anywhere
        if ($urandom_range(3) == 0) smp = 24'($urandom);
        else smp = 24'(est_now + $signed($urandom_range(1 << 18)) - (1 << 17));
        send_word(smp, ($urandom_range(19) == 0) || i == 0, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("%0d sample words over %0d register settings, %0d results checked, %0d clipped",
             words_sent, PHASES, words_checked, sat_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sat_pkg.sv
rtl/core/sat_front.sv
rtl/core/sat_back.sv
rtl/core/stochastic_approximation_tracker_unit.sv
verif/stochastic_approximation_tracker_unit_tb.sv
